@@ hdl/prs_pkg.sv @@
// prs_pkg: shared types and constants for the permutation rank sum block
// used by the front end, the back end and the top level; depends on nothing

package prs_pkg;

   // fixed field widths
   localparam int VAL_W      = 6;   // element value and digit width
   localparam int CNT_W      = 7;   // counts that must hold 64
   localparam int CHUNK_W    = 8;   // bits per popcount chunk
   localparam int CHUNK_CNT_W = 4;  // popcount of one chunk, 0..8
   localparam int REM_W      = 3;   // rank left over inside one chunk

   // queue between the front end and the back end
   localparam int Q_DEPTH = 4;
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   typedef logic [VAL_W-1:0] value_type;
   typedef logic [CNT_W-1:0] count_type;

   // one classified input word, handed from front end to back end
   typedef struct packed {
      logic [VAL_W-1:0] digit;     // saturated lehmer digit
      logic             phase_b;   // digit belongs to the second permutation
      logic             perm_end;  // last digit of its permutation
      logic             err;       // error seen so far in this batch
   } digit_word_type;

endpackage

@@ hdl/prs_ram.sv @@
// prs_ram: generic single write port, single read port ram with registered read
// no package dependencies

module prs_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/prs_fifo.sv @@
// prs_fifo: small register queue that decouples the front end from the back end
// no package dependencies; width and depth come from the instantiating module

module prs_fifo #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign do_wr = wr_en && (count_ff != CW'(DEPTH));
   assign do_rd = rd_en && (count_ff != '0);

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = slot_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign count   = count_ff;

endmodule

@@ hdl/prs_front.sv @@
// prs_front: accepts element words, tracks unused values and errors, and
// turns each element into a saturated lehmer digit; depends on prs_pkg

module prs_front
   import prs_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           restart,
   input  count_type      len,
   input  logic           push,
   output logic           full,
   input  value_type      elem_value,
   input  logic [QCNT_W-1:0] q_count,
   output logic           q_push,
   output digit_word_type q_word
);

   localparam int CHUNKS = (MAX_LEN + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_W  = CHUNKS * CHUNK_W;

   function automatic logic [CHUNK_CNT_W-1:0] popcount8(input logic [CHUNK_W-1:0] bits);
      logic [CHUNK_CNT_W-1:0] acc;
      acc = '0;
      for (int b = 0; b < CHUNK_W; b++) begin
         acc = acc + CHUNK_CNT_W'(bits[b]);
      end
      return acc;
   endfunction

   // permutation tracking state
   logic [PAD_W-1:0] unused_ff, unused_in;
   count_type        idx_ff, idx_in;
   logic             phase_ff, phase_in;
   logic             err_ff, err_in;

   // registered stage: chunk counts of the masked unused map
   logic                   va_ff;
   logic [CHUNK_CNT_W-1:0] cnt_ff [CHUNKS];
   logic [CHUNK_CNT_W-1:0] cnt_in [CHUNKS];
   count_type              limit_ff, limit_in;
   logic                   phase_b_ff, end_ff, werr_ff;

   logic             take, oob, hit, err_now, end_now;
   count_type        below, idx_next;
   logic [PAD_W-1:0] masked;

   // space check counts the word still in the registered stage
   assign full = (q_count + QCNT_W'(va_ff)) >= QCNT_W'(Q_DEPTH);
   assign take = push && !full;

   // classify the incoming element
   always_comb begin
      oob = ({1'b0, elem_value} >= len);
      hit = 1'b0;
      for (int j = 0; j < PAD_W; j++) begin
         hit = hit | (unused_ff[j] & (elem_value == VAL_W'(j)));
      end
      below = oob ? len : {1'b0, elem_value};
      for (int j = 0; j < PAD_W; j++) begin
         masked[j] = unused_ff[j] & (CNT_W'(j) < below);
      end
      for (int c = 0; c < CHUNKS; c++) begin
         cnt_in[c] = popcount8(masked[c*CHUNK_W +: CHUNK_W]);
      end
      limit_in = len - CNT_W'(1) - idx_ff;
      err_now  = err_ff | oob | !hit;
      idx_next = idx_ff + 1'b1;
      end_now  = (idx_next == len);
   end

   // next state of the permutation tracker
   always_comb begin
      unused_in = unused_ff;
      idx_in    = idx_ff;
      phase_in  = phase_ff;
      err_in    = err_ff;
      if (restart) begin
         unused_in = '1;
         idx_in    = '0;
         phase_in  = 1'b0;
         err_in    = 1'b0;
      end else if (take) begin
         for (int j = 0; j < PAD_W; j++) begin
            unused_in[j] = unused_ff[j] & (elem_value != VAL_W'(j));
         end
         idx_in = idx_next;
         err_in = err_now;
         if (end_now) begin
            unused_in = '1;
            idx_in    = '0;
            phase_in  = !phase_ff;
            if (phase_ff) begin
               err_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unused_ff <= '1;
         idx_ff    <= '0;
         phase_ff  <= 1'b0;
         err_ff    <= 1'b0;
         va_ff     <= 1'b0;
      end else begin
         unused_ff <= unused_in;
         idx_ff    <= idx_in;
         phase_ff  <= phase_in;
         err_ff    <= err_in;
         va_ff     <= take && !restart;
      end
   end

   // payload of the registered stage
   always_ff @(posedge clock) begin
      if (take) begin
         cnt_ff     <= cnt_in;
         limit_ff   <= limit_in;
         phase_b_ff <= phase_ff;
         end_ff     <= end_now;
         werr_ff    <= err_now;
      end
   end

   // sum the chunk counts and saturate the digit
   count_type sum;
   always_comb begin
      sum = '0;
      for (int c = 0; c < CHUNKS; c++) begin
         sum = sum + CNT_W'(cnt_ff[c]);
      end
      q_word.digit    = (sum > limit_ff) ? limit_ff[VAL_W-1:0] : sum[VAL_W-1:0];
      q_word.phase_b  = phase_b_ff;
      q_word.perm_end = end_ff;
      q_word.err      = werr_ff;
   end

   assign q_push = va_ff;

endmodule

@@ hdl/prs_back.sv @@
// prs_back: stores lehmer digits, adds them in the factorial base and unranks
// the sum into the result words; depends on prs_pkg and prs_ram

module prs_back
   import prs_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           restart,
   input  count_type      len,
   input  logic           q_empty,
   input  digit_word_type q_word,
   output logic           q_pop,
   output logic           empty,
   input  logic           pop,
   output value_type      result_value,
   output logic           last_flag,
   output logic           input_error
);

   localparam int CHUNKS = (MAX_LEN + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_W  = CHUNKS * CHUNK_W;
   localparam int IDX_W  = $clog2(MAX_LEN);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ADD,
      ST_URD,
      ST_USEL,
      ST_UPICK
   } state_type;

   state_type              state_ff, state_in;
   count_type              pos_ff, pos_in;
   logic                   issue_ff, issue_in;
   logic                   rdv_ff, rdv_in;
   count_type              rdpos_ff, rdpos_in;
   logic                   carry_ff, carry_in;
   logic                   err_ff, err_in;
   logic [PAD_W-1:0]       avail_ff, avail_in;
   logic [CHUNK_CNT_W-1:0] cnt_ff [CHUNKS];
   logic [CHUNK_CNT_W-1:0] cnt_in [CHUNKS];
   logic [CHUNKS-1:0]      sel_ff, sel_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic                   out_valid_ff, out_valid_in;
   value_type              out_value_ff, out_value_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_err_ff, out_err_in;

   // digit ram ports
   logic             wa_en, wb_en;
   logic [IDX_W-1:0] waddr, raddr;
   value_type        wdata, rdata_a, rdata_b;

   // first digits, later overwritten by the sum digits
   prs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_ram_a (
      .clock   (clock),
      .wr_en   (wa_en),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata_a)
   );

   // second digits
   prs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_ram_b (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata_b)
   );

   // factorial base digit add with one compare and subtract
   count_type sum_raw, radix, sum_red;
   logic      sum_ge;
   always_comb begin
      sum_raw = CNT_W'(rdata_a) + CNT_W'(rdata_b) + CNT_W'(carry_ff);
      radix   = len - rdpos_ff;
      sum_ge  = (sum_raw >= radix);
      sum_red = sum_ge ? (sum_raw - radix) : sum_raw;
   end

   // chunk holding the wanted unused value
   count_type         rem_walk;
   logic              found;
   logic [CHUNKS-1:0] sel_walk;
   always_comb begin
      rem_walk = CNT_W'(rdata_a);
      found    = 1'b0;
      sel_walk = '0;
      for (int c = 0; c < CHUNKS; c++) begin
         if (!found) begin
            if (rem_walk < CNT_W'(cnt_ff[c])) begin
               sel_walk[c] = 1'b1;
               found       = 1'b1;
            end else begin
               rem_walk = rem_walk - CNT_W'(cnt_ff[c]);
            end
         end
      end
   end

   // pick the wanted set bit inside the selected chunk
   logic [CHUNK_W-1:0] chunk_bits;
   value_type          chunk_base;
   logic [REM_W-1:0]   off, seen;
   logic               got;
   value_type          pick_value;
   always_comb begin
      chunk_bits = '0;
      chunk_base = '0;
      for (int c = 0; c < CHUNKS; c++) begin
         if (sel_ff[c]) begin
            chunk_bits = chunk_bits | avail_ff[c*CHUNK_W +: CHUNK_W];
            chunk_base = chunk_base | VAL_W'(c * CHUNK_W);
         end
      end
      off  = '0;
      seen = '0;
      got  = 1'b0;
      for (int b = 0; b < CHUNK_W; b++) begin
         if (chunk_bits[b] && !got) begin
            if (seen == rem_ff) begin
               off = REM_W'(b);
               got = 1'b1;
            end else begin
               seen = seen + 1'b1;
            end
         end
      end
      pick_value = chunk_base | VAL_W'(off);
   end

   logic      pop_fire, pick_fire, pick_last;
   count_type pos_inc;

   assign pop_fire  = pop && out_valid_ff;
   assign pick_fire = !out_valid_ff || pop_fire;
   assign pos_inc   = pos_ff + 1'b1;
   assign pick_last = (pos_inc == len);

   // sequencer: load digits, add pass, unrank pass
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      issue_in     = issue_ff;
      rdv_in       = 1'b0;
      rdpos_in     = rdpos_ff;
      carry_in     = carry_ff;
      err_in       = err_ff;
      avail_in     = avail_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      q_pop        = 1'b0;
      wa_en        = 1'b0;
      wb_en        = 1'b0;
      waddr        = pos_ff[IDX_W-1:0];
      wdata        = q_word.digit;
      raddr        = pos_ff[IDX_W-1:0];

      if (pop_fire) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         // store digits as the front end delivers them
         ST_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               wa_en = !q_word.phase_b;
               wb_en = q_word.phase_b;
               pos_in = pos_inc;
               if (q_word.perm_end) begin
                  pos_in = '0;
                  if (q_word.phase_b) begin
                     err_in   = q_word.err;
                     pos_in   = len - CNT_W'(1);
                     issue_in = 1'b1;
                     carry_in = 1'b0;
                     state_in = ST_ADD;
                  end
               end
            end
            // a length write drops a partly loaded batch
            if (restart) begin
               pos_in   = '0;
               issue_in = 1'b0;
               state_in = ST_LOAD;
            end
         end

         // read one position per cycle, add it in the following cycle
         ST_ADD: begin
            rdv_in   = issue_ff;
            rdpos_in = pos_ff;
            if (issue_ff) begin
               if (pos_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
            if (rdv_ff) begin
               wa_en    = 1'b1;
               waddr    = rdpos_ff[IDX_W-1:0];
               wdata    = sum_red[VAL_W-1:0];
               carry_in = sum_ge;
               if (rdpos_ff == '0) begin
                  pos_in   = '0;
                  state_in = ST_URD;
                  for (int j = 0; j < PAD_W; j++) begin
                     avail_in[j] = (CNT_W'(j) < len);
                  end
                  for (int c = 0; c < CHUNKS; c++) begin
                     if (len >= CNT_W'((c + 1) * CHUNK_W)) begin
                        cnt_in[c] = CHUNK_CNT_W'(CHUNK_W);
                     end else if (len > CNT_W'(c * CHUNK_W)) begin
                        cnt_in[c] = CHUNK_CNT_W'(len - CNT_W'(c * CHUNK_W));
                     end else begin
                        cnt_in[c] = '0;
                     end
                  end
               end
            end
         end

         // first sum digit read
         ST_URD: begin
            state_in = ST_USEL;
         end

         // choose the chunk of the wanted value
         ST_USEL: begin
            sel_in   = sel_walk;
            rem_in   = rem_walk[REM_W-1:0];
            state_in = ST_UPICK;
         end

         // emit the value, prefetch the next sum digit
         ST_UPICK: begin
            raddr = pos_inc[IDX_W-1:0];
            if (pick_fire) begin
               out_valid_in = 1'b1;
               out_value_in = pick_value;
               out_last_in  = pick_last;
               out_err_in   = err_ff;
               for (int j = 0; j < PAD_W; j++) begin
                  if (sel_ff[j / CHUNK_W] && (REM_W'(j % CHUNK_W) == off)) begin
                     avail_in[j] = 1'b0;
                  end
               end
               for (int c = 0; c < CHUNKS; c++) begin
                  cnt_in[c] = cnt_ff[c] - CHUNK_CNT_W'(sel_ff[c]);
               end
               if (pick_last) begin
                  pos_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  pos_in   = pos_inc;
                  state_in = ST_USEL;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pos_ff       <= '0;
         issue_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         issue_ff     <= issue_in;
         rdv_ff       <= rdv_in;
         out_valid_ff <= out_valid_in;
      end
      rdpos_ff     <= rdpos_in;
      carry_ff     <= carry_in;
      err_ff       <= err_in;
      avail_ff     <= avail_in;
      cnt_ff       <= cnt_in;
      sel_ff       <= sel_in;
      rem_ff       <= rem_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   assign empty        = !out_valid_ff;
   assign result_value = out_value_ff;
   assign last_flag    = out_last_ff;
   assign input_error  = out_err_ff;

endmodule

@@ hdl/permutation_rank_sum.sv @@
// permutation_rank_sum: top level, length register and the front/queue/back chain
// depends on prs_pkg, prs_front, prs_fifo, prs_back (and prs_ram through prs_back)
//
//   port group  direction  handshake          payload
//   req_        in         push / full        req_elem_value
//   rsp_        out        empty / pop        rsp_result_value, rsp_last_flag,
//                                             rsp_input_error
//   csr_        in         csr_wr_en          csr_wr_data (permutation length)
//
// the front end takes one word per cycle while full is low; its digit goes through
// one register and a four word queue, so a full back end stalls input only once
// the queue fills. after the last word of the second permutation the back end runs
// the factorial base add (one ram read port), the first sum digit read and then the
// unrank search for each result word; a batch is 2n input words.
// reset is synchronous; no clearing pass, the digit rams are written before read.
// a length write restarts loading and empties the digit queue.
// a result word waits in the output register while pop is low; unranking then
// holds, while the front end keeps loading the next batch until the queue is full.

module permutation_rank_sum
   import prs_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  value_type  req_elem_value,
   output logic       empty,
   input  logic       pop,
   output value_type  rsp_result_value,
   output logic       rsp_last_flag,
   output logic       rsp_input_error,
   input  logic       csr_wr_en,
   input  count_type  csr_wr_data
);

   localparam int WORD_W = $bits(digit_word_type);

   // effective permutation length, kept in range 1..MAX_LEN
   count_type len_ff, len_in;
   always_comb begin
      len_in = len_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            len_in = CNT_W'(1);
         end else if (csr_wr_data > CNT_W'(MAX_LEN)) begin
            len_in = CNT_W'(MAX_LEN);
         end else begin
            len_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= CNT_W'(MAX_LEN);
      end else begin
         len_ff <= len_in;
      end
   end

   logic              q_push, q_pop, q_empty, q_flush;
   digit_word_type    q_wr_word, q_rd_word;
   logic [WORD_W-1:0] q_rd_bits;
   logic [QCNT_W-1:0] q_count;

   // a length write drops any queued digits
   assign q_flush = reset || csr_wr_en;

   // element intake and digit generation
   prs_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_wr_en),
      .len        (len_ff),
      .push       (push),
      .full       (full),
      .elem_value (req_elem_value),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_word     (q_wr_word)
   );

   // digit queue
   prs_fifo #(.WIDTH(WORD_W), .DEPTH(Q_DEPTH)) u_fifo (
      .clock   (clock),
      .reset   (q_flush),
      .wr_en   (q_push),
      .wr_data (q_wr_word),
      .rd_en   (q_pop),
      .rd_data (q_rd_bits),
      .empty   (q_empty),
      .count   (q_count)
   );

   assign q_rd_word = digit_word_type'(q_rd_bits);

   // digit storage, rank add and unrank
   prs_back #(.MAX_LEN(MAX_LEN)) u_back (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_wr_en),
      .len          (len_ff),
      .q_empty      (q_empty),
      .q_word       (q_rd_word),
      .q_pop        (q_pop),
      .empty        (empty),
      .pop          (pop),
      .result_value (rsp_result_value),
      .last_flag    (rsp_last_flag),
      .input_error  (rsp_input_error)
   );

endmodule
